// File: sv/mps_pkg.sv
// shared types and constants for the multiband pixel statistics core
`timescale 1ns / 1ps

package mps_pkg;

  localparam int unsigned MaxBands  = 256;
  localparam int unsigned CntW      = 9;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned SumW      = 25;
  localparam int unsigned SqW       = 39;
  localparam int unsigned ProdW     = 48;
  localparam int unsigned DenW      = 16;
  localparam int unsigned StatW     = 32;
  localparam int unsigned RootInW   = 32;
  localparam int unsigned RootW     = 16;
  localparam int unsigned StepW     = 6;
  localparam logic [StepW-1:0] DivLastStep  = StepW'(ProdW - 1);
  localparam logic [StepW-1:0] RootLastStep = StepW'(RootW - 1);

  // configuration register indexes
  localparam logic [1:0] CfgStatMode     = 2'd0;
  localparam logic [1:0] CfgNodataEnable = 2'd1;
  localparam logic [1:0] CfgNodataValue  = 2'd2;

  // statistic selector codes
  localparam logic [2:0] ModeMin = 3'd0;
  localparam logic [2:0] ModeMax = 3'd1;
  localparam logic [2:0] ModeAvg = 3'd2;
  localparam logic [2:0] ModeSum = 3'd3;
  localparam logic [2:0] ModeStd = 3'd4;
  localparam logic [2:0] ModeVar = 3'd5;

  typedef enum logic [6:0] {
    ST_ACC    = 7'b0000001,
    ST_PROD   = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_ROOTLD = 7'b0010000,
    ST_ROOT   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic accum;      // sample transfer, update running values
    logic prod;       // register products and denominator
    logic div_load;   // load divider operands
    logic div_step;   // one quotient bit
    logic root_load;  // load square root operand
    logic root_step;  // one root bit
    logic finish;     // write result register and clear pixel state
  } cmd_t;

  typedef struct packed {
    logic direct;     // result needs no divide
    logic is_std;     // deviation requested
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

// File: sv/mps_ctrl.sv
// controller state machine for the multiband pixel statistics core
`timescale 1ns / 1ps

module mps_ctrl import mps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_ready_o = (state_q == ST_ACC);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_ACC: begin
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          if (in_last_i) state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = status_i.direct ? ST_DONE : ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + StepW'(1);
        if (step_q == DivLastStep) state_d = status_i.is_std ? ST_ROOTLD : ST_DONE;
      end
      ST_ROOTLD: begin
        cmd_o.root_load = 1'b1;
        step_d  = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d = step_q + StepW'(1);
        if (step_q == RootLastStep) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: sv/mps_dp.sv
// datapath: accumulators, products, divider, square root and result register
`timescale 1ns / 1ps

module mps_dp import mps_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [2:0]                stat_mode_i,
  input  logic                      nodata_enable_i,
  input  logic signed [SampleW-1:0] nodata_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [StatW-1:0]          stat_value_o,
  output logic                      masked_o,
  output logic                      bad_count_o
);

  logic [CntW-1:0]           cnt_q;
  logic signed [SampleW-1:0] min_q, max_q;
  logic signed [SumW-1:0]    sum_q;
  logic [SqW-1:0]            sq_q;
  logic                      seen_q;

  logic [ProdW-1:0] nq_q, ss_q;
  logic [DenW-1:0]  den_q;
  logic [ProdW-1:0] quo_q;
  logic [DenW-1:0]  rem_q;
  logic [RootInW-1:0] rx_q;
  logic [RootW:0]     rrem_q;
  logic [RootW-1:0]   root_q;

  logic             out_valid_q;
  logic [StatW-1:0] stat_q;
  logic             masked_q, bad_q;

  // pixel flags
  logic over, few, var_mode, bad;
  assign over     = (cnt_q > CntW'(MaxBands));
  assign var_mode = (stat_mode_i == ModeStd) || (stat_mode_i == ModeVar);
  assign few      = (cnt_q < CntW'(2));
  assign bad      = over || (var_mode && few);

  assign status_o.direct   = bad || seen_q || (stat_mode_i == ModeMin) ||
                             (stat_mode_i == ModeMax) || (stat_mode_i == ModeSum);
  assign status_o.is_std   = (stat_mode_i == ModeStd);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // accumulators
  logic signed [2*SampleW-1:0] sq_sample;
  assign sq_sample = sample_i * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.accum) begin
      if (nodata_enable_i && (sample_i == nodata_value_i)) seen_q <= 1'b1;
      if (cnt_q < CntW'(MaxBands)) begin
        if (cnt_q == '0) begin
          min_q <= sample_i;
          max_q <= sample_i;
        end else begin
          if (sample_i < min_q) min_q <= sample_i;
          if (sample_i > max_q) max_q <= sample_i;
        end
        sum_q <= sum_q + SumW'(sample_i);
        sq_q  <= sq_q + SqW'(unsigned'(sq_sample));
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        cnt_q <= CntW'(MaxBands + 1);
      end
    end else if (cmd_i.finish) begin
      cnt_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      seen_q <= 1'b0;
    end
  end

  // magnitude of the sum
  logic [SumW-1:0] sum_abs;
  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  logic [CntW-1:0] cnt_m1;
  assign cnt_m1 = cnt_q - CntW'(1);

  // products for the variance numerator
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      nq_q  <= ProdW'(cnt_q * sq_q);
      ss_q  <= ProdW'(sum_abs * sum_abs);
      den_q <= DenW'(cnt_q * cnt_m1);
    end
  end

  logic [ProdW:0] num_diff;
  assign num_diff = {1'b0, nq_q} - {1'b0, ss_q};

  // restoring divider, one quotient bit a cycle
  logic [DenW:0]   div_trial;
  logic [DenW-1:0] divisor_q;
  assign div_trial = {rem_q, quo_q[ProdW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      if (stat_mode_i == ModeStd || stat_mode_i == ModeVar) begin
        quo_q     <= num_diff[ProdW] ? '0 : num_diff[ProdW-1:0];
        divisor_q <= den_q;
      end else begin
        quo_q     <= ProdW'(sum_abs);
        divisor_q <= DenW'(cnt_q);
      end
    end else if (cmd_i.div_step) begin
      if (div_trial >= {1'b0, divisor_q}) begin
        rem_q <= DenW'(div_trial - {1'b0, divisor_q});
        quo_q <= {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_q <= div_trial[DenW-1:0];
        quo_q <= {quo_q[ProdW-2:0], 1'b0};
      end
    end
  end

  // quotient clipped to the positive range of the result
  logic [StatW-1:0] quo_sat;
  assign quo_sat = (quo_q > ProdW'(32'h7fff_ffff)) ? 32'h7fff_ffff : quo_q[StatW-1:0];

  // digit-by-digit square root, one root bit a cycle
  logic [RootW+2:0] root_part, root_trial;
  assign root_part  = {rrem_q, rx_q[RootInW-1 -: 2]};
  assign root_trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      rx_q   <= quo_sat;
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rx_q <= {rx_q[RootInW-3:0], 2'b00};
      if (root_part >= root_trial) begin
        rrem_q <= (RootW+1)'(root_part - root_trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rrem_q <= root_part[RootW:0];
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  // result selection
  logic [StatW-1:0] result;
  logic [StatW-1:0] avg_mag;
  assign avg_mag = StatW'(quo_q[SumW-1:0]);

  always_comb begin
    if (bad || seen_q) begin
      result = '0;
    end else begin
      unique case (stat_mode_i)
        ModeMin: result = StatW'(signed'(min_q));
        ModeMax: result = StatW'(signed'(max_q));
        ModeSum: result = StatW'(signed'(sum_q));
        ModeStd: result = StatW'(root_q);
        ModeVar: result = quo_sat;
        default: result = sum_q[SumW-1] ? StatW'(-avg_mag) : avg_mag;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      stat_q   <= result;
      masked_q <= seen_q;
      bad_q    <= bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stat_value_o = stat_q;
  assign masked_o     = masked_q;
  assign bad_count_o  = bad_q;

endmodule

// File: sv/multiband_pixel_statistics_core.sv
// top level of the multiband pixel statistics core
`timescale 1ns / 1ps

// Takes the band samples of one pixel, one transfer per cycle, with tlast on
// the final band, and returns one result per pixel: min, max, average, sum,
// sample variance or floor standard deviation, chosen by stat_mode. Bands are
// taken at one per cycle; after the last band the core stops taking samples
// while it finishes the pixel: a products state and the finishing state for
// min, max, sum or a masked or bad pixel; average and variance add a divider
// load and the bit-serial divider steps; deviation adds a load and 16
// bit-serial square root steps. The finishing cycle waits while the output
// register still holds an untaken result. The result then sits in an output
// register while the next pixel streams in. Result flags travel on tuser.
// Configuration is to be written while idle; the core does not enforce it.

module multiband_pixel_statistics_core import mps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // band samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,   // last band
  // pixel results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] stat_value
  output logic [1:0]  m_axis_tuser    // [0] masked, [1] bad_count
);

  // configuration registers
  logic [2:0]                stat_mode_q;
  logic                      nodata_enable_q;
  logic signed [SampleW-1:0] nodata_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_mode_q     <= ModeAvg;
      nodata_enable_q <= 1'b0;
      nodata_value_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStatMode:     stat_mode_q     <= cfg_data_i[2:0];
        CfgNodataEnable: nodata_enable_q <= cfg_data_i[0];
        CfgNodataValue:  nodata_value_q  <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  cmd_t    cmd;
  status_t status;

  // sequencer: accumulate, products, divide, root, hand off result
  mps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mps_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_i        (signed'(s_axis_tdata)),
    .stat_mode_i     (stat_mode_q),
    .nodata_enable_i (nodata_enable_q),
    .nodata_value_i  (nodata_value_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .stat_value_o    (m_axis_tdata),
    .masked_o        (m_axis_tuser[0]),
    .bad_count_o     (m_axis_tuser[1])
  );

endmodule

// File: tb/sv/mps_checker.sv
// checker for the multiband pixel statistics core: predicts and compares results
`timescale 1ns / 1ps

module mps_checker import mps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          err_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] value;
    logic        masked;
    logic        bad;
  } pix_stat_t;

  pix_stat_t pix_q[$];

  logic [2:0]         mode_r;
  logic               nd_en_r;
  logic signed [15:0] nd_val_r;
  int unsigned        bands;
  longint             mn, mx, sum;
  longint             sumsq;
  logic               nd_seen;

  function automatic longint floor_root(longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x) r = r + (longint'(1) << b);
    end
    return r;
  endfunction

  function automatic pix_stat_t pixel_result();
    pix_stat_t p;
    longint    res, num, den, n;
    res = 0;
    n = bands;
    p.masked = nd_seen;
    p.bad = (bands > MaxBands);
    if (!p.bad) begin
      case (mode_r)
        ModeMin: res = mn;
        ModeMax: res = mx;
        ModeSum: res = sum;
        ModeStd, ModeVar: begin
          if (n < 2) p.bad = 1'b1;
          else begin
            num = n * sumsq - sum * sum;
            den = n * (n - 1);
            if (num < 0) num = 0;
            res = num / den;
            if (mode_r == ModeStd) res = floor_root(res);
          end
        end
        default: res = sum / n;  // average, also unused codes
      endcase
    end
    if (p.bad || p.masked) res = 0;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    p.value = res[31:0];
    return p;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    pix_stat_t exp_p;
    longint    s;
    if (!rst_ni) begin
      mode_r <= ModeAvg; nd_en_r <= 1'b0; nd_val_r <= '0;
      bands = 0; mn = 0; mx = 0; sum = 0; sumsq = 0; nd_seen = 1'b0;
      err_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStatMode:     mode_r <= cfg_data_i[2:0];
          CfgNodataEnable: nd_en_r <= cfg_data_i[0];
          CfgNodataValue:  nd_val_r <= cfg_data_i;
          default: ;
        endcase
      end
      // band transfer: blocking updates so the last band sees its own sample
      if (s_axis_tvalid && s_axis_tready) begin
        s = longint'($signed(s_axis_tdata));
        if (nd_en_r && $signed(s_axis_tdata) == nd_val_r) nd_seen = 1'b1;
        if (bands < MaxBands) begin
          if (bands == 0) begin mn = s; mx = s; end
          else begin
            if (s < mn) mn = s;
            if (s > mx) mx = s;
          end
          sum = sum + s;
          sumsq = sumsq + s * s;
          bands = bands + 1;
        end else bands = MaxBands + 1;
        if (s_axis_tlast) begin
          pix_q.push_back(pixel_result());
          bands = 0; mn = 0; mx = 0; sum = 0; sumsq = 0; nd_seen = 1'b0;
        end
      end
      // result transfer
      if (m_axis_tvalid && m_axis_tready) begin
        if (pix_q.size() == 0) begin
          if (err_count_o < 10) $display("unexpected result %h", m_axis_tdata);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_p = pix_q.pop_front();
          if (exp_p.value !== m_axis_tdata || exp_p.masked !== m_axis_tuser[0]
              || exp_p.bad !== m_axis_tuser[1]) begin
            if (err_count_o < 10)
              $display("mismatch: exp %h m%b b%b, got %h m%b b%b", exp_p.value,
                       exp_p.masked, exp_p.bad, m_axis_tdata, m_axis_tuser[0],
                       m_axis_tuser[1]);
            err_count_o <= err_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = pix_q.size();

endmodule

// File: tb/sv/tb_top.sv
// stimulus and verdict for the multiband pixel statistics core
`timescale 1ns / 1ps

module tb_top import mps_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          err_count, pending;

  // idle percentages for sender and receiver, and the long hold-off
  int unsigned send_idle = 0, recv_stall = 0;
  bit          hold_off = 1'b0;
  int unsigned hold_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  multiband_pixel_statistics_core u_top (.*);

  mps_checker u_chk (
    .err_count_o(err_count), .pending_o(pending), .*
  );

  // receiver: random stalls plus an optional long stretch of back-pressure
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_off) begin
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // one band transfer, with random idle cycles before it; called at a rising
  // edge, returns at the edge of the transfer with tvalid still high
  task automatic send_band(input logic [15:0] smp, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sample biased toward extremes and toward the nodata value
  function automatic logic [15:0] pick_sample(input logic [15:0] nd);
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return nd;
      3: return 16'($urandom_range(7)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input int nb, input logic [15:0] nd);
    for (int i = 0; i < nb; i++) send_band(pick_sample(nd), i == nb - 1);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stop sending, wait for every pixel result, then let the core settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] nd;
    int          nb;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset mode is average
    send_band(16'h7fff, 1'b0); send_band(16'h7fff, 1'b1);
    send_band(16'h8000, 1'b1);
    for (int m = 0; m < 8; m++) begin
      drain();
      write_cfg(CfgStatMode, 16'(m));
      send_band(16'h8000, 1'b0); send_band(16'h7fff, 1'b0); send_band(16'h0005, 1'b1);
      send_band(16'hfff0, 1'b1);  // single band
    end
    // too many bands, then masking
    drain();
    write_cfg(CfgStatMode, {13'd0, ModeVar});
    for (int i = 0; i < 257; i++) send_band(16'h7fff, i == 256);
    drain();
    write_cfg(CfgNodataEnable, 16'h0001);
    write_cfg(CfgNodataValue, 16'h8000);
    send_band(16'h0001, 1'b0); send_band(16'h8000, 1'b0); send_band(16'h0002, 1'b1);
    // nodata only in a band past the bound
    for (int i = 0; i < 258; i++) send_band(i == 257 ? 16'h8000 : 16'h0003, i == 257);

    // random phases of idling and settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      nd = (ph == 5) ? 16'h7fff : 16'($urandom);
      write_cfg(CfgStatMode, 16'($urandom_range(7)));
      write_cfg(CfgNodataEnable, 16'($urandom_range(1)));
      write_cfg(CfgNodataValue, nd);
      if (ph == 4) begin
        // start one long hold-off, then keep offering bands into it
        hold_off = 1'b1;
        wait (hold_left != 0);
        hold_off = 1'b0;
      end
      for (int p = 0; p < 3; p++) begin
        case ($urandom_range(9))
          0: nb = 1;
          1: nb = 2;
          default: nb = $urandom_range(2, 5);
        endcase
        send_pixel(nb, nd);
      end
    end

    drain();
    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
